// ===== rtl/core/ertk_pkg.sv =====
// Shared types and constants of the expert routing histogram block.
`default_nettype none
package ertk_pkg;

  localparam int DEF_MAX_LAYERS  = 64;
  localparam int DEF_MAX_EXPERTS = 64;
  localparam int DEF_MAX_BATCH   = 16;
  localparam int DEF_COUNT_BITS  = 32;

  localparam logic [6:0] CFG_RESET_VALUE = 7'd64;

  // Commands
  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_COUNT   = 2'd1;
  localparam logic [1:0] CMD_RANK    = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_COMMIT = 3'd0;
  localparam logic [2:0] ST_REJECT = 3'd1;
  localparam logic [2:0] ST_COUNT  = 3'd2;
  localparam logic [2:0] ST_RANKED = 3'd3;
  localparam logic [2:0] ST_EMPTY  = 3'd4;

  // Register indexes
  localparam logic [0:0] REG_NUM_LAYERS  = 1'd0;
  localparam logic [0:0] REG_NUM_EXPERTS = 1'd1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PRD,
    S_CRD,
    S_CWR,
    S_TRD,
    S_TWR,
    S_QOUT,
    S_RTOT,
    S_RSCAN,
    S_REMIT
  } ertk_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/ertk_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module ertk_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/expert_route_histogram_topk_core.sv =====
// Top level: per-layer expert hit histogram with batch commit and top-k ranking.
//
// Usage:
//   Command channel: an item is taken when start is high and busy is low.
//   Observe items (one expert id each) collect into a pending batch; the item
//   with in_last high ends it. An observe item without in_last gives no word
//   and leaves busy low. A closing item commits the batch (states S_PRD, S_CRD,
//   S_CWR per id, then S_TRD, S_TWR for the layer total) or rejects it at once.
//   A count query answers in S_QOUT after RAM reads (in idle if out of range).
//   A rank query gives n results: each result is one pass of the shared
//   comparator over the layer's counters, one counter RAM read per cycle.
//   Result channel: out_strobe marks each result word for exactly one cycle;
//   the receiver cannot hold words off. out_last_out ends every reply run.
//   Configuration: cfg_we writes register cfg_index (0 num_layers,
//   1 num_experts); write only while the block is idle.
//   Reset: synchronous, active low. After reset the block sweeps the counter
//   store (MAX_LAYERS * MAX_EXPERTS entries) and the layer totals clear with
//   busy high; configuration writes are taken meanwhile.
`default_nettype none
module expert_route_histogram_topk_core
  import ertk_pkg::*;
#(
  parameter int MAX_LAYERS  = DEF_MAX_LAYERS,
  parameter int MAX_EXPERTS = DEF_MAX_EXPERTS,
  parameter int MAX_BATCH   = DEF_MAX_BATCH,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_command,
  input  wire logic [6:0]         in_layer,
  input  wire logic signed [15:0] in_expert_id,
  input  wire logic               in_last,
  input  wire logic [6:0]         in_hot_count,
  output logic                    out_strobe,
  output logic [2:0]              out_status,
  output logic [5:0]              out_expert_out,
  output logic [31:0]             out_count_out,
  output logic [31:0]             out_layer_total_out,
  output logic                    out_last_out,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [6:0]         cfg_wdata
);

  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int EW    = $clog2(MAX_EXPERTS);
  localparam int BW    = $clog2(MAX_BATCH + 1);
  localparam int PW    = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int DEPTH = MAX_LAYERS * MAX_EXPERTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = COUNT_BITS;

  localparam logic [CW-1:0] CMAX = {CW{1'b1}};

  function automatic logic [AW-1:0] cidx(input logic [LW-1:0] l, input logic [EW-1:0] e);
    return AW'(l) * AW'(MAX_EXPERTS) + AW'(e);
  endfunction

  function automatic logic [31:0] low32(input logic [CW-1:0] v);
    logic [CW+31:0] w;
    w = {32'd0, v};
    return w[31:0];
  endfunction

  ertk_state_t state_r, state_nxt;

  logic [6:0]    num_layers_r, num_experts_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [BW-1:0] plen_r, plen_nxt;
  logic [LW-1:0] player_r, player_nxt;
  logic          pbad_r, pbad_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] caddr_r, caddr_nxt;
  logic [LW-1:0] layer_r, layer_nxt;
  logic [6:0]    n_r, n_nxt, k_r, k_nxt;
  logic [EW:0]   e_r, e_nxt;
  logic          rdv_r, rdv_nxt;
  logic [EW-1:0] rde_r, rde_nxt;
  logic [EW-1:0] best_r, best_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic          have_r, have_nxt;
  logic [CW-1:0] tot_r, tot_nxt;
  logic [MAX_EXPERTS-1:0] picked_r, picked_nxt;

  // RAM ports
  logic          c_we, t_we, p_we;
  logic [AW-1:0] c_waddr, c_raddr;
  logic [CW-1:0] c_wdata, c_rdata;
  logic [LW-1:0] t_waddr, t_raddr;
  logic [CW-1:0] t_wdata, t_rdata;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [EW-1:0] p_rdata;

  // Result word
  logic        emit;
  logic [2:0]  em_status;
  logic [5:0]  em_expert;
  logic [31:0] em_count, em_total;
  logic        em_last;

  logic          accept;
  logic [7:0]    eff_l;
  logic [6:0]    eff_e;
  logic          layer_ok, id_ok, first, len_ok, obs_bad;
  logic [6:0]    hot_n;
  logic [CW:0]   tsum;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign eff_l = ({1'b0, num_layers_r} > 8'(MAX_LAYERS)) ? 8'(MAX_LAYERS)
                                                         : {1'b0, num_layers_r};
  assign eff_e = (num_experts_r > 7'(MAX_EXPERTS)) ? 7'(MAX_EXPERTS) : num_experts_r;
  assign layer_ok = ({1'b0, in_layer} < eff_l);
  assign id_ok    = !in_expert_id[15] && (in_expert_id[14:0] < 15'(eff_e));
  assign len_ok   = (plen_r < BW'(MAX_BATCH));
  assign first    = (plen_r == '0) && !pbad_r;
  assign obs_bad  = pbad_r || (first && !layer_ok) || !id_ok || !len_ok;
  assign hot_n    = (in_hot_count < eff_e) ? in_hot_count : eff_e;
  assign tsum     = {1'b0, t_rdata} + (CW+1)'(plen_r);

  ertk_ram #(.DEPTH(DEPTH), .WIDTH(CW), .AW(AW)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  ertk_ram #(.DEPTH(MAX_LAYERS), .WIDTH(CW), .AW(LW)) u_tot_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  ertk_ram #(.DEPTH(MAX_BATCH), .WIDTH(EW), .AW(PW)) u_pend_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(in_expert_id[EW-1:0]),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:   if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_OBSERVE: if (in_last && !obs_bad) state_nxt = S_PRD;
            CMD_COUNT:   if (layer_ok && id_ok) state_nxt = S_QOUT;
            CMD_RANK:    if (layer_ok && in_hot_count != '0 && eff_e != '0)
                           state_nxt = S_RTOT;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_PRD:   state_nxt = S_CRD;
      S_CRD:   state_nxt = S_CWR;
      S_CWR:   state_nxt = (idx_r + 1'b1 == plen_r) ? S_TRD : S_PRD;
      S_TRD:   state_nxt = S_TWR;
      S_TWR:   state_nxt = S_IDLE;
      S_QOUT:  state_nxt = S_IDLE;
      S_RTOT:  state_nxt = S_RSCAN;
      S_RSCAN: if (7'(e_r) >= eff_e && !rdv_r) state_nxt = S_REMIT;
      S_REMIT: state_nxt = (k_r + 1'b1 == n_r) ? S_IDLE : S_RSCAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    clr_nxt    = clr_r;
    plen_nxt   = plen_r;
    player_nxt = player_r;
    pbad_nxt   = pbad_r;
    idx_nxt    = idx_r;
    caddr_nxt  = caddr_r;
    layer_nxt  = layer_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    e_nxt      = e_r;
    rdv_nxt    = 1'b0;
    rde_nxt    = rde_r;
    best_nxt   = best_r;
    bc_nxt     = bc_r;
    have_nxt   = have_r;
    tot_nxt    = tot_r;
    picked_nxt = picked_r;

    c_we    = 1'b0;
    c_waddr = caddr_r;
    c_wdata = '0;
    c_raddr = cidx(LW'(in_layer), in_expert_id[EW-1:0]);
    t_we    = 1'b0;
    t_waddr = player_r;
    t_wdata = '0;
    t_raddr = LW'(in_layer);
    p_we    = 1'b0;
    p_waddr = PW'(plen_r);
    p_raddr = PW'(idx_r);

    emit      = 1'b0;
    em_status = ST_COMMIT;
    em_expert = '0;
    em_count  = '0;
    em_total  = '0;
    em_last   = 1'b1;

    unique case (state_r)
      S_CLR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
        t_we    = (clr_r < AW'(MAX_LAYERS));
        t_waddr = LW'(clr_r);
        clr_nxt = clr_r + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_OBSERVE: begin
              if (first) player_nxt = LW'(in_layer);
              if (id_ok && len_ok) begin
                p_we     = 1'b1;
                plen_nxt = plen_r + 1'b1;
              end
              pbad_nxt = obs_bad;
              idx_nxt  = '0;
              if (in_last && obs_bad) begin
                emit       = 1'b1;
                em_status  = ST_REJECT;
                plen_nxt   = '0;
                player_nxt = '0;
                pbad_nxt   = 1'b0;
              end
            end
            CMD_COUNT: begin
              if (!(layer_ok && id_ok)) begin
                emit      = 1'b1;
                em_status = ST_COUNT;
              end
            end
            CMD_RANK: begin
              picked_nxt = '0;
              layer_nxt  = LW'(in_layer);
              n_nxt      = hot_n;
              k_nxt      = '0;
              if (!(layer_ok && in_hot_count != '0 && eff_e != '0)) begin
                emit      = 1'b1;
                em_status = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_PRD: ;
      S_CRD: begin
        c_raddr   = cidx(player_r, p_rdata);
        caddr_nxt = cidx(player_r, p_rdata);
      end
      S_CWR: begin
        c_we    = 1'b1;
        c_wdata = (c_rdata == CMAX) ? CMAX : c_rdata + 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      S_TRD: t_raddr = player_r;
      S_TWR: begin
        t_we       = 1'b1;
        t_wdata    = (tsum[CW] || tsum[CW-1:0] == CMAX) ? CMAX : tsum[CW-1:0];
        emit       = 1'b1;
        em_status  = ST_COMMIT;
        em_total   = low32(t_wdata);
        plen_nxt   = '0;
        player_nxt = '0;
        pbad_nxt   = 1'b0;
      end
      S_QOUT: begin
        emit      = 1'b1;
        em_status = ST_COUNT;
        em_count  = low32(c_rdata);
        em_total  = low32(t_rdata);
      end
      S_RTOT: begin
        tot_nxt  = t_rdata;
        e_nxt    = '0;
        have_nxt = 1'b0;
      end
      S_RSCAN: begin
        c_raddr = cidx(layer_r, e_r[EW-1:0]);
        if (7'(e_r) < eff_e) begin
          rdv_nxt = 1'b1;
          rde_nxt = e_r[EW-1:0];
          e_nxt   = e_r + 1'b1;
        end
        // Strict compare keeps the lower index on ties.
        if (rdv_r && !picked_r[rde_r] && (!have_r || c_rdata > bc_r)) begin
          have_nxt = 1'b1;
          best_nxt = rde_r;
          bc_nxt   = c_rdata;
        end
      end
      S_REMIT: begin
        emit       = 1'b1;
        em_status  = ST_RANKED;
        em_expert  = 6'(best_r);
        em_count   = low32(bc_r);
        em_total   = low32(tot_r);
        em_last    = (k_r + 1'b1 == n_r);
        picked_nxt = picked_r | (MAX_EXPERTS'(1) << best_r);
        k_nxt      = k_r + 1'b1;
        e_nxt      = '0;
        have_nxt   = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      num_layers_r  <= CFG_RESET_VALUE;
      num_experts_r <= CFG_RESET_VALUE;
      clr_r         <= '0;
      plen_r        <= '0;
      player_r      <= '0;
      pbad_r        <= 1'b0;
      rdv_r         <= 1'b0;
      picked_r      <= '0;
      out_strobe    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      plen_r     <= plen_nxt;
      player_r   <= player_nxt;
      pbad_r     <= pbad_nxt;
      rdv_r      <= rdv_nxt;
      picked_r   <= picked_nxt;
      out_strobe <= emit;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_LAYERS:  num_layers_r  <= cfg_wdata;
          REG_NUM_EXPERTS: num_experts_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    caddr_r   <= caddr_nxt;
    layer_r   <= layer_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    e_r       <= e_nxt;
    rde_r     <= rde_nxt;
    best_r    <= best_nxt;
    bc_r      <= bc_nxt;
    have_r    <= have_nxt;
    tot_r     <= tot_nxt;
    out_status          <= em_status;
    out_expert_out      <= em_expert;
    out_count_out       <= em_count;
    out_layer_total_out <= em_total;
    out_last_out        <= em_last;
  end

  a_no_word_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !emit) else $error("result word during clear sweep");

  a_count_answers: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == CMD_COUNT |=> out_strobe || state_r == S_QOUT)
    else $error("count query not answered");

  a_rank_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REMIT |=> out_strobe) else $error("ranked word lost");

  a_batch_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= BW'(MAX_BATCH)) else $error("pending batch overflow");

  a_commit_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TWR |=> plen_r == '0 && !pbad_r && out_strobe)
    else $error("batch not closed on commit");

endmodule
`default_nettype wire
